@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked concurrent assertions with a reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of clk while rst is low.
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that cond implies prop in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   `ASSERT_AT(label, clk, rst, (cond) |-> (prop), msg)

`endif

@@ src/mi3_pkg.sv @@
// ---------------------------------------------------------------------------
// mi3_pkg
// Widths, request types and index tables of the 3x3 matrix inverter.
// ---------------------------------------------------------------------------
package mi3_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // A 2x2 product and a cofactor (difference of two products).
   localparam int PROD_W = 2 * DATA_WIDTH;
   localparam int COF_W  = 2 * DATA_WIDTH + 1;
   // The cofactor is split into an unsigned low part and a signed high part.
   localparam int LO_W   = DATA_WIDTH + 1;
   localparam int HI_W   = COF_W - LO_W;
   localparam int LOP_W  = DATA_WIDTH + LO_W + 1;
   localparam int HIP_W  = DATA_WIDTH + HI_W;
   // Determinant, with headroom for the three-term sum.
   localparam int DET_W  = 3 * DATA_WIDTH + 3;
   // Working width of the divider remainder.
   localparam int XA_W   = 2 * DATA_WIDTH + 2 * FRAC_BITS + 3;
   localparam int XB_W   = DET_W + DATA_WIDTH + 2;
   localparam int X_W    = (XA_W > XB_W) ? XA_W : XB_W;

   localparam int FRONT_LAT   = 5;
   localparam int DIV_LAT     = DATA_WIDTH + 4;
   localparam int QUEUE_DEPTH = 4;

   // Cofactor k = a[MX]*a[MY] - a[NX]*a[NY], entries numbered row by row.
   localparam int MX [9] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
   localparam int MY [9] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
   localparam int NX [9] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
   localparam int NY [9] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] a11;
      logic signed [DATA_WIDTH-1:0] a12;
      logic signed [DATA_WIDTH-1:0] a13;
      logic signed [DATA_WIDTH-1:0] a21;
      logic signed [DATA_WIDTH-1:0] a22;
      logic signed [DATA_WIDTH-1:0] a23;
      logic signed [DATA_WIDTH-1:0] a31;
      logic signed [DATA_WIDTH-1:0] a32;
      logic signed [DATA_WIDTH-1:0] a33;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] r11;
      logic signed [DATA_WIDTH-1:0] r12;
      logic signed [DATA_WIDTH-1:0] r13;
      logic signed [DATA_WIDTH-1:0] r21;
      logic signed [DATA_WIDTH-1:0] r22;
      logic signed [DATA_WIDTH-1:0] r23;
      logic signed [DATA_WIDTH-1:0] r31;
      logic signed [DATA_WIDTH-1:0] r32;
      logic signed [DATA_WIDTH-1:0] r33;
      logic                         singular;
   } rsp_type;

   // Classified request handed from the front to the back.
   typedef struct packed {
      logic [8:0][COF_W-1:0] cof;
      logic [DET_W-1:0]      det;
      logic                  singular;
   } mid_type;

endpackage

@@ src/mi3_front.sv @@
// ---------------------------------------------------------------------------
// mi3_front
// Accepts matrices, forms the cofactors and the determinant, classifies.
// ---------------------------------------------------------------------------
module mi3_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mi3_pkg::req_type  req_data,
   output logic              full,
   input  logic              q_full,
   output logic              q_push,
   output mi3_pkg::mid_type  q_data
);

   localparam int DW = mi3_pkg::DATA_WIDTH;

   logic signed [DW-1:0] a [9];
   logic [mi3_pkg::FRONT_LAT-1:0] v_ff;
   logic adv;
   logic take;

   logic signed [mi3_pkg::PROD_W-1:0] p0_ff [9];
   logic signed [mi3_pkg::PROD_W-1:0] p1_ff [9];
   logic signed [DW-1:0] row1_ff  [3];
   logic signed [DW-1:0] row1b_ff [3];
   logic signed [mi3_pkg::COF_W-1:0] cof2_ff [9];
   logic signed [mi3_pkg::COF_W-1:0] cof3_ff [9];
   logic signed [mi3_pkg::COF_W-1:0] cof4_ff [9];
   logic signed [mi3_pkg::COF_W-1:0] cof5_ff [9];
   logic signed [mi3_pkg::LOP_W-1:0] lo_ff [3];
   logic signed [mi3_pkg::HIP_W-1:0] hi_ff [3];
   logic signed [mi3_pkg::DET_W-1:0] term_ff [3];
   logic signed [mi3_pkg::DET_W-1:0] det_ff;

   assign a[0] = req_data.a11;
   assign a[1] = req_data.a12;
   assign a[2] = req_data.a13;
   assign a[3] = req_data.a21;
   assign a[4] = req_data.a22;
   assign a[5] = req_data.a23;
   assign a[6] = req_data.a31;
   assign a[7] = req_data.a32;
   assign a[8] = req_data.a33;

   assign adv    = !v_ff[mi3_pkg::FRONT_LAT-1] || !q_full;
   assign full   = !adv;
   assign take   = push && adv;
   assign q_push = v_ff[mi3_pkg::FRONT_LAT-1] && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[mi3_pkg::FRONT_LAT-2:0], take};
      end
   end

   for (genvar k = 0; k < 9; k++) begin : g_cof
      always_ff @(posedge clock) begin
         if (adv) begin
            p0_ff[k]   <= a[mi3_pkg::MX[k]] * a[mi3_pkg::MY[k]];
            p1_ff[k]   <= a[mi3_pkg::NX[k]] * a[mi3_pkg::NY[k]];
            cof2_ff[k] <= $signed({p0_ff[k][mi3_pkg::PROD_W-1], p0_ff[k]})
                        - $signed({p1_ff[k][mi3_pkg::PROD_W-1], p1_ff[k]});
            cof3_ff[k] <= cof2_ff[k];
            cof4_ff[k] <= cof3_ff[k];
            cof5_ff[k] <= cof4_ff[k];
         end
      end
      assign q_data.cof[k] = cof5_ff[k];
   end

   // Row 1 times its cofactors, each cofactor taken in two narrower halves.
   for (genvar j = 0; j < 3; j++) begin : g_det
      always_ff @(posedge clock) begin
         if (adv) begin
            row1_ff[j]  <= a[j];
            row1b_ff[j] <= row1_ff[j];
            lo_ff[j]    <= row1b_ff[j] * $signed({1'b0, cof2_ff[j][mi3_pkg::LO_W-1:0]});
            hi_ff[j]    <= row1b_ff[j] * $signed(cof2_ff[j][mi3_pkg::COF_W-1:mi3_pkg::LO_W]);
            term_ff[j]  <= (mi3_pkg::DET_W'(hi_ff[j]) <<< mi3_pkg::LO_W)
                         + mi3_pkg::DET_W'(lo_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         det_ff <= term_ff[0] + term_ff[1] + term_ff[2];
      end
   end

   assign q_data.det      = det_ff;
   assign q_data.singular = (det_ff == '0);

endmodule

@@ src/mi3_queue.sv @@
// ---------------------------------------------------------------------------
// mi3_queue
// Short first-in first-out queue between the front and the back.
// ---------------------------------------------------------------------------
module mi3_queue #(
   parameter int DEPTH = mi3_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mi3_pkg::mid_type  wdata,
   output logic              full,
   input  logic              pop,
   output mi3_pkg::mid_type  rdata,
   output logic              empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   mi3_pkg::mid_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ src/mi3_div.sv @@
// ---------------------------------------------------------------------------
// mi3_div
// Pipelined rounding divider: one cofactor over the determinant, saturated.
// ---------------------------------------------------------------------------
module mi3_div (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [mi3_pkg::COF_W-1:0]     cof,
   input  logic [mi3_pkg::DET_W-1:0]     det,
   output logic [mi3_pkg::DATA_WIDTH-1:0] quo
);

   localparam int DW = mi3_pkg::DATA_WIDTH;
   localparam int CW = mi3_pkg::COF_W;
   localparam int EW = mi3_pkg::DET_W;
   localparam int XW = mi3_pkg::X_W;
   localparam int VW = mi3_pkg::DET_W + 1;

   logic [CW-1:0] magc_ff;
   logic [EW-1:0] magd_ff;
   logic          neg0_ff;
   logic [XW-1:0] n_ff;
   logic [VW-1:0] v1_ff;
   logic          neg1_ff;

   // Index 0 is after the overflow check, index DW after the last bit.
   logic [XW-1:0] r_ff   [DW+1];
   logic [DW-1:0] q_ff   [DW+1];
   logic [VW-1:0] v_ff   [DW+1];
   logic          neg_ff [DW+1];
   logic          ovf_ff [DW+1];

   logic [DW-1:0] res_in;
   logic [DW-1:0] res_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         neg0_ff <= cof[CW-1] ^ det[EW-1];
         magc_ff <= cof[CW-1] ? (~cof + 1'b1) : cof;
         magd_ff <= det[EW-1] ? (~det + 1'b1) : det;
         // Numerator carries the half-divisor so that the floor rounds.
         n_ff    <= (XW'(magc_ff) << (2 * mi3_pkg::FRAC_BITS + 1)) + XW'(magd_ff);
         v1_ff   <= {magd_ff, 1'b0};
         neg1_ff <= neg0_ff;
         r_ff[0]   <= n_ff;
         q_ff[0]   <= '0;
         v_ff[0]   <= v1_ff;
         neg_ff[0] <= neg1_ff;
         ovf_ff[0] <= (n_ff >= (XW'(v1_ff) << DW));
      end
   end

   for (genvar k = 0; k < DW; k++) begin : g_bit
      localparam int B = DW - 1 - k;
      logic [XW-1:0] dsh;
      logic          ge;
      assign dsh = XW'(v_ff[k]) << B;
      assign ge  = (r_ff[k] >= dsh);
      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[k+1]   <= ge ? (r_ff[k] - dsh) : r_ff[k];
            q_ff[k+1]   <= q_ff[k] | (DW'(ge) << B);
            v_ff[k+1]   <= v_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   always_comb begin
      if (!neg_ff[DW]) begin
         res_in = (ovf_ff[DW] || q_ff[DW][DW-1]) ? {1'b0, {(DW-1){1'b1}}} : q_ff[DW];
      end else begin
         res_in = (ovf_ff[DW] || (q_ff[DW] > (DW'(1) << (DW - 1))))
                ? {1'b1, {(DW-1){1'b0}}} : (~q_ff[DW] + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
   end

   assign quo = res_ff;

endmodule

@@ src/mi3_back.sv @@
// ---------------------------------------------------------------------------
// mi3_back
// Nine divider pipelines that turn cofactors into inverse entries.
// ---------------------------------------------------------------------------
module mi3_back (
   input  logic              clock,
   input  logic              reset,
   input  mi3_pkg::mid_type  q_data,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              empty,
   input  logic              pop,
   output mi3_pkg::rsp_type  rsp_data
);

   localparam int DW  = mi3_pkg::DATA_WIDTH;
   localparam int LAT = mi3_pkg::DIV_LAT;

   logic [LAT-1:0] v_ff;
   logic [LAT-1:0] sing_ff;
   logic           adv;
   logic [DW-1:0]  quo [9];
   logic [DW-1:0]  ent [9];

   assign adv   = !v_ff[LAT-1] || pop;
   assign q_pop = adv && !q_empty;
   assign empty = !v_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[LAT-2:0], q_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sing_ff <= {sing_ff[LAT-2:0], q_data.singular};
      end
   end

   // Entry (i, j) of the inverse is cofactor (j, i) over the determinant.
   for (genvar p = 0; p < 9; p++) begin : g_ent
      localparam int I = p / 3;
      localparam int J = p % 3;
      mi3_div u_div (
         .clock (clock),
         .adv   (adv),
         .cof   (q_data.cof[J * 3 + I]),
         .det   (q_data.det),
         .quo   (quo[p])
      );
      assign ent[p] = sing_ff[LAT-1] ? '0 : quo[p];
   end

   assign rsp_data.r11      = ent[0];
   assign rsp_data.r12      = ent[1];
   assign rsp_data.r13      = ent[2];
   assign rsp_data.r21      = ent[3];
   assign rsp_data.r22      = ent[4];
   assign rsp_data.r23      = ent[5];
   assign rsp_data.r31      = ent[6];
   assign rsp_data.r32      = ent[7];
   assign rsp_data.r33      = ent[8];
   assign rsp_data.singular = sing_ff[LAT-1];

endmodule

@@ src/matrix_inverse_3x3.sv @@
// ---------------------------------------------------------------------------
// matrix_inverse_3x3
// Inverse of a 3x3 Q16.16 matrix by adjugate over determinant.
// ---------------------------------------------------------------------------
// A request is one matrix on req_data; it is taken at a rising edge where
// push is high and full is low. Results leave in request order: while empty
// is low the oldest result is on rsp_data, and it is taken at a rising edge
// where pop is high. Each entry is rounded to nearest, ties away from zero,
// and saturated; a zero determinant gives all-zero entries with singular set.
// A request passes through the front (products, cofactors, split determinant
// products and their sum), the queue and the back, where each of the 32
// quotient bits has its own compare-and-subtract stage. One request can be
// taken every cycle while full is low, so the throughput is one matrix per
// cycle while the receiver keeps popping.
// Reset empties the pipelines and the queue; no other state is kept.
// When the receiver stops popping, the back holds, the queue between front
// and back fills, and only then does full rise to hold off new requests.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_inverse_3x3 #(
   parameter int QUEUE_DEPTH = mi3_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  mi3_pkg::req_type  req_data,
   output logic              empty,
   input  logic              pop,
   output mi3_pkg::rsp_type  rsp_data
);

   // Queue handshake between the front and the back.
   logic             q_push;
   logic             q_full;
   logic             q_pop;
   logic             q_empty;
   mi3_pkg::mid_type q_wdata;
   mi3_pkg::mid_type q_rdata;
   logic             rsp_nonzero;

   // The front computes the cofactors and determinant and marks singular
   // matrices; it stalls only when the queue is full.
   mi3_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wdata)
   );

   mi3_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   // The back divides the nine transposed cofactors by the determinant.
   mi3_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_data   (q_rdata),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // Any entry bit set in the presented result.
   assign rsp_nonzero = |{rsp_data.r11, rsp_data.r12, rsp_data.r13,
                          rsp_data.r21, rsp_data.r22, rsp_data.r23,
                          rsp_data.r31, rsp_data.r32, rsp_data.r33};

   `ASSERT_IMPLY(a_singular_zero, clock, reset, !empty && rsp_data.singular, !rsp_nonzero, "singular result has a nonzero entry")
   `ASSERT_IMPLY(a_no_push_full, clock, reset, q_push, !q_full, "front pushed into a full queue")
   `ASSERT_IMPLY(a_no_pop_empty, clock, reset, q_pop, !q_empty, "back popped an empty queue")

endmodule

@@ tb/matrix_inverse_3x3_checker.sv @@
// ---------------------------------------------------------------------------
// matrix_inverse_3x3_checker
// Watches the request and result channels of the inverter, predicts each
// result and compares it, entry by entry, with what the block delivers.
// ---------------------------------------------------------------------------
module matrix_inverse_3x3_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             full,
   input  mi3_pkg::req_type req_data,
   input  logic             empty,
   input  logic             pop,
   input  mi3_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending_count
);
   import mi3_pkg::*;

   localparam int WW = 256;

   rsp_type expected_inverses[$];

   // Rounded and saturated quotient of one cofactor by the determinant.
   function automatic logic signed [DATA_WIDTH-1:0] scaled_quotient(
      logic signed [WW-1:0] cofactor, logic signed [WW-1:0] determinant);
      logic [WW-1:0] mag;
      logic [WW-1:0] den;
      logic [WW-1:0] q;
      logic [WW-1:0] lim;
      logic          neg;
      neg = (cofactor < 0) != (determinant < 0);
      mag = (cofactor < 0) ? -cofactor : cofactor;
      den = (determinant < 0) ? -determinant : determinant;
      q   = ((mag << (2 * FRAC_BITS + 1)) + den) / (den << 1);
      lim = WW'(1) << (DATA_WIDTH - 1);
      if (!neg)
         return (q >= lim) ? DATA_WIDTH'(lim - 1) : DATA_WIDTH'(q);
      return (q >= lim) ? DATA_WIDTH'(lim) : DATA_WIDTH'(-q);
   endfunction

   function automatic rsp_type predict_inverse(req_type m);
      logic signed [WW-1:0] e[9];
      logic signed [WW-1:0] c[9];
      logic signed [WW-1:0] det;
      logic [8:0][DATA_WIDTH-1:0] r;
      rsp_type res;
      e = '{m.a11, m.a12, m.a13, m.a21, m.a22, m.a23, m.a31, m.a32, m.a33};
      c[0] = e[4] * e[8] - e[5] * e[7];
      c[1] = -(e[3] * e[8] - e[5] * e[6]);
      c[2] = e[3] * e[7] - e[4] * e[6];
      c[3] = -(e[1] * e[8] - e[2] * e[7]);
      c[4] = e[0] * e[8] - e[2] * e[6];
      c[5] = -(e[0] * e[7] - e[1] * e[6]);
      c[6] = e[1] * e[5] - e[2] * e[4];
      c[7] = -(e[0] * e[5] - e[2] * e[3]);
      c[8] = e[0] * e[4] - e[1] * e[3];
      det = e[0] * c[0] + e[1] * c[1] + e[2] * c[2];
      if (det == 0) begin
         res = '0;
         res.singular = 1'b1;
         return res;
      end
      // The inverse takes the transposed cofactors.
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            r[8 - (i * 3 + j)] = scaled_quotient(c[j * 3 + i], det);
      res = {r, 1'b0};
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [DATA_WIDTH-1:0] got,
                                  logic [DATA_WIDTH-1:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   assign pending_count = expected_inverses.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         error_count = 0;
      end else begin
         if (push && !full)
            expected_inverses.push_back(predict_inverse(req_data));
         if (pop && !empty) begin
            if (expected_inverses.size() == 0) begin
               report_mismatch("unexpected result", '0, '0);
            end else begin
               want = expected_inverses.pop_front();
               if (rsp_data.r11 !== want.r11) report_mismatch("r11", rsp_data.r11, want.r11);
               if (rsp_data.r12 !== want.r12) report_mismatch("r12", rsp_data.r12, want.r12);
               if (rsp_data.r13 !== want.r13) report_mismatch("r13", rsp_data.r13, want.r13);
               if (rsp_data.r21 !== want.r21) report_mismatch("r21", rsp_data.r21, want.r21);
               if (rsp_data.r22 !== want.r22) report_mismatch("r22", rsp_data.r22, want.r22);
               if (rsp_data.r23 !== want.r23) report_mismatch("r23", rsp_data.r23, want.r23);
               if (rsp_data.r31 !== want.r31) report_mismatch("r31", rsp_data.r31, want.r31);
               if (rsp_data.r32 !== want.r32) report_mismatch("r32", rsp_data.r32, want.r32);
               if (rsp_data.r33 !== want.r33) report_mismatch("r33", rsp_data.r33, want.r33);
               if (rsp_data.singular !== want.singular)
                  report_mismatch("singular", DATA_WIDTH'(rsp_data.singular),
                                  DATA_WIDTH'(want.singular));
            end
         end
      end
   end
endmodule

@@ tb/matrix_inverse_3x3_test.sv @@
// ---------------------------------------------------------------------------
// matrix_inverse_3x3_test
// Drives matrices into the inverter with random gaps and stalls, and gives
// the verdict from the checker's mismatch count.
// ---------------------------------------------------------------------------
module matrix_inverse_3x3_test;
   import mi3_pkg::*;

   localparam int RANDOM_REQUESTS = 2000;
   // No acceptance on either side for this long means the block has hung.
   localparam int IDLE_LIMIT      = 2000;
   // Latency of an empty block plus margin, waited after the last result.
   localparam int DRAIN_CYCLES    = 60;
   localparam logic [31:0] ONE_Q  = 32'h0001_0000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push  = 1'b0;
   logic    pop   = 1'b0;
   logic    full;
   logic    empty;
   req_type req_data = '0;
   rsp_type rsp_data;
   int      error_count;
   int      pending_count;
   int      idle_cycles = 0;
   logic    stimulus_done = 1'b0;

   always #6 clock = ~clock;

   matrix_inverse_3x3 u_top (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   matrix_inverse_3x3_checker u_checker (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .error_count(error_count), .pending_count(pending_count)
   );

   // Draws a random gap length; at least a third of the time it is zero,
   // so that long back-to-back stretches occur as well.
   function automatic int draw_gap();
      return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
   endfunction

   // A random entry: fully random, from -3.0 to 3.0, an extreme, or raw -8 to 7.
   function automatic logic [31:0] random_entry();
      case ($urandom_range(0, 5))
         0, 1: return $urandom();
         2, 3: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
         4: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return $urandom_range(0, 15) - 8;
      endcase
   endfunction

   function automatic req_type random_matrix();
      req_type m;
      m = {random_entry(), random_entry(), random_entry(), random_entry(), random_entry(),
           random_entry(), random_entry(), random_entry(), random_entry()};
      // Now and then copy one row onto another so that the determinant is zero.
      if ($urandom_range(0, 9) == 0) begin
         m.a31 = m.a11;
         m.a32 = m.a12;
         m.a33 = m.a13;
      end
      return m;
   endfunction

   // Presents one request and holds it until the block takes it. Push stays
   // high into the next request when that one follows without a gap.
   task automatic send_request(req_type m);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= m;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   function automatic req_type diagonal(logic [31:0] d1, logic [31:0] d2, logic [31:0] d3);
      req_type m;
      m = '0;
      m.a11 = d1;
      m.a22 = d2;
      m.a33 = d3;
      return m;
   endfunction

   // Receiver: pops with its own random stalls, independent of the sender.
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (pop && !empty) begin
               gap = draw_gap();
               if (gap > 0) begin
                  pop <= 1'b0;
                  repeat (gap) @(posedge clock);
                  pop <= 1'b1;
               end
            end else begin
               pop <= 1'b1;
            end
         end
      end
   end

   // Watchdog: counts cycles in which no request and no result is accepted.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      req_type m;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed matrices: identity, scaled diagonals, zero, extremes and patterns.
      send_request(diagonal(ONE_Q, ONE_Q, ONE_Q));
      send_request(diagonal(32'h0002_0000, 32'hfffe_0000, 32'h0000_8000));
      send_request('0);
      send_request(diagonal(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
      send_request(diagonal(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
      send_request(diagonal(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_request(diagonal(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
      send_request({9{32'hffff_ffff}});
      send_request({9{32'h8000_0000}});
      send_request({9{32'h7fff_ffff}});
      send_request({9{32'h5555_5555}});
      send_request({9{32'haaaa_aaaa}});
      // A non-diagonal matrix with determinant three, giving inexact thirds.
      m = {ONE_Q, 32'h0002_0000, 32'h0, 32'h0, ONE_Q, 32'h0, 32'h0, 32'h0, 32'h0003_0000};
      send_request(m);
      // Further scaled diagonals, one of them with a tiny entry.
      send_request(diagonal(32'h0002_0000, 32'hfffe_0000, 32'h0008_0000));
      send_request(diagonal(32'h0000_0003, 32'h0003_0000, 32'hfffd_0000));
      // Permutation matrix with a negative determinant.
      m = '0;
      m.a12 = ONE_Q;
      m.a21 = ONE_Q;
      m.a33 = ONE_Q;
      send_request(m);

      for (int n = 0; n < RANDOM_REQUESTS; n++)
         send_request(random_matrix());
      push          <= 1'b0;
      stimulus_done <= 1'b1;
   end

   // Verdict once every result has come back and the block has settled.
   initial begin
      wait (stimulus_done);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
